/* src/twsc_pkg.sv */
package twsc_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned CurW  = 31;
  localparam int unsigned TolW  = 16;

  // Register map, one word per register
  typedef enum logic [2:0] {
    REG_TOTAL = 3'd0,
    REG_MODE  = 3'd1,
    REG_END   = 3'd2,
    REG_STEP  = 3'd3,
    REG_HOLD  = 3'd4
  } twsc_reg_e;

  typedef enum logic [1:0] {
    MODE_FWD = 2'd0,
    MODE_BWD = 2'd1,
    MODE_CCW = 2'd2,
    MODE_CW  = 2'd3
  } twsc_mode_e;

  typedef struct packed {
    logic [CurW-1:0] total;
    twsc_mode_e      mode;
    logic [TolW-1:0] end_tol;
    logic [TolW-1:0] step_tol;
    logic [TolW-1:0] hold;
  } twsc_cfg_t;

  // What one wheel lane reports to the merge stage
  typedef struct packed {
    logic [TickW-1:0] target;
    logic             track_ok;
    logic             end_ok;
  } twsc_lane_t;

  typedef struct packed {
    logic             drive_valid;
    logic [TickW-1:0] right_target;
    logic [TickW-1:0] left_target;
    logic [CurW-1:0]  progress_cursor;
    logic             correction_request;
    logic             move_finished;
  } twsc_res_t;

endpackage

/* src/twsc_if.sv */
interface twsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] right_ticks;
  logic signed [31:0] left_ticks;

  modport source (output valid, output right_ticks, output left_ticks, input ready);
  modport sink (input valid, input right_ticks, input left_ticks, output ready);
endinterface

interface twsc_out_if;
  logic               valid;
  logic               ready;
  logic               drive_valid;
  logic signed [31:0] right_target;
  logic signed [31:0] left_target;
  logic        [30:0] progress_cursor;
  logic               correction_request;
  logic               move_finished;

  modport source (output valid, output drive_valid, output right_target,
                  output left_target, output progress_cursor,
                  output correction_request, output move_finished, input ready);
  modport sink (input valid, input drive_valid, input right_target,
                input left_target, input progress_cursor,
                input correction_request, input move_finished, output ready);
endinterface

/* src/two_wheel_step_trajectory_cursor_unit.sv */
// Two-wheel step trajectory cursor.
// Software writes total_move_ticks, motion_mode, end_tolerance,
// step_tolerance and hold_ticks over the APB port (byte addresses 0 to 16)
// while no beat is in flight, then feeds one beat per control tick on in_i
// carrying both encoder counts. Each accepted beat yields exactly one result
// beat on out_o: wheel targets, the cursor, a correction request and the
// finished flag. The first beat after reset latches the wheel references.
// The result is registered: a beat accepted in one cycle is shown on out_o
// in the next. One beat per cycle is sustained while out_o.ready stays high;
// the right and left lanes work in parallel and the merge stage updates
// cursor, counter and finish flag in the same cycle.
// The result sits in an output register; while the receiver stalls, in_i
// still takes a beat whenever that register is empty, otherwise in_i.ready
// drops and the held result stays unchanged.
// Reset clears the references, cursor, counter, flags and configuration, but not the result payload register.
module two_wheel_step_trajectory_cursor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  twsc_in_if.sink     in_i,
  twsc_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import twsc_pkg::*;

  twsc_cfg_t   cfg;
  twsc_lane_t  right_res, left_res;
  twsc_res_t   res;
  logic        captured, cap_en;
  logic [30:0] cursor;
  logic        right_neg, left_neg;

  twsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Wheel signs from the motion mode
  assign right_neg = (cfg.mode == MODE_BWD) || (cfg.mode == MODE_CW);
  assign left_neg  = (cfg.mode == MODE_BWD) || (cfg.mode == MODE_CCW);

  twsc_lane u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_en_i   (cap_en),
    .captured_i (captured),
    .neg_i      (right_neg),
    .ticks_i    (in_i.right_ticks),
    .cursor_i   (cursor),
    .total_i    (cfg.total),
    .end_tol_i  (cfg.end_tol),
    .step_tol_i (cfg.step_tol),
    .res_o      (right_res)
  );

  twsc_lane u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_en_i   (cap_en),
    .captured_i (captured),
    .neg_i      (left_neg),
    .ticks_i    (in_i.left_ticks),
    .cursor_i   (cursor),
    .total_i    (cfg.total),
    .end_tol_i  (cfg.end_tol),
    .step_tol_i (cfg.step_tol),
    .res_o      (left_res)
  );

  twsc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cfg_i       (cfg),
    .right_i     (right_res),
    .left_i      (left_res),
    .captured_o  (captured),
    .cap_en_o    (cap_en),
    .cursor_o    (cursor),
    .res_o       (res)
  );

  // Drive the result beat
  assign out_o.drive_valid        = res.drive_valid;
  assign out_o.right_target       = res.right_target;
  assign out_o.left_target        = res.left_target;
  assign out_o.progress_cursor    = res.progress_cursor;
  assign out_o.correction_request = res.correction_request;
  assign out_o.move_finished      = res.move_finished;

endmodule

/* src/twsc_cfg.sv */
module twsc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output twsc_pkg::twsc_cfg_t cfg_o
);
  import twsc_pkg::*;

  twsc_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  twsc_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = twsc_reg_e'(paddr[4:2]);

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_TOTAL: cfg_d.total    = pwdata[CurW-1:0];
        REG_MODE:  cfg_d.mode     = twsc_mode_e'(pwdata[1:0]);
        REG_END:   cfg_d.end_tol  = pwdata[TolW-1:0];
        REG_STEP:  cfg_d.step_tol = pwdata[TolW-1:0];
        REG_HOLD:  cfg_d.hold     = pwdata[TolW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_TOTAL: prdata = {1'b0, cfg_q.total};
      REG_MODE:  prdata = {30'd0, cfg_q.mode};
      REG_END:   prdata = {16'd0, cfg_q.end_tol};
      REG_STEP:  prdata = {16'd0, cfg_q.step_tol};
      REG_HOLD:  prdata = {16'd0, cfg_q.hold};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/twsc_lane.sv */
module twsc_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cap_en_i,
  input  logic                 captured_i,
  input  logic                 neg_i,
  input  logic [31:0]          ticks_i,
  input  logic [30:0]          cursor_i,
  input  logic [30:0]          total_i,
  input  logic [15:0]          end_tol_i,
  input  logic [15:0]          step_tol_i,
  output twsc_pkg::twsc_lane_t res_o
);
  import twsc_pkg::*;

  logic [31:0] ref_q;
  logic [31:0] ref_eff;
  logic [31:0] cur_signed;
  logic [32:0] pos_diff, pos_mag;
  logic [32:0] tot_signed, end_pos, end_mag;
  logic [32:0] ticks_ext, ticks_mag;
  logic [33:0] cur_w, step_w, tol_w;

  // Latch the wheel reference on the first tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cap_en_i) begin
      ref_q <= ticks_i;
    end
  end

  // Target: reference plus signed cursor, wrapping
  assign cur_signed   = neg_i ? (~{1'b0, cursor_i} + 32'd1) : {1'b0, cursor_i};
  assign res_o.target = ref_q + cur_signed;

  assign cur_w  = {3'd0, cursor_i};
  assign step_w = {18'd0, step_tol_i};
  assign tol_w  = {18'd0, end_tol_i};

  // Tracking: |cursor - |ticks - ref|| <= step
  assign pos_diff = {ticks_i[31], ticks_i} - {ref_q[31], ref_q};
  assign pos_mag  = pos_diff[32] ? (~pos_diff + 33'd1) : pos_diff;
  assign res_o.track_ok = ({1'b0, pos_mag} <= cur_w + step_w) &&
                          (cur_w <= {1'b0, pos_mag} + step_w);

  // End check: ||ref + sign*total| - |ticks|| <= end tolerance
  assign ref_eff    = captured_i ? ref_q : ticks_i;
  assign tot_signed = neg_i ? (~{2'b00, total_i} + 33'd1) : {2'b00, total_i};
  assign end_pos    = {ref_eff[31], ref_eff} + tot_signed;
  assign end_mag    = end_pos[32] ? (~end_pos + 33'd1) : end_pos;
  assign ticks_ext  = {ticks_i[31], ticks_i};
  assign ticks_mag  = ticks_ext[32] ? (~ticks_ext + 33'd1) : ticks_ext;
  assign res_o.end_ok = ({1'b0, end_mag} <= {1'b0, ticks_mag} + tol_w) &&
                        ({1'b0, ticks_mag} <= {1'b0, end_mag} + tol_w);

endmodule

/* src/twsc_merge.sv */
module twsc_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  twsc_pkg::twsc_cfg_t  cfg_i,
  input  twsc_pkg::twsc_lane_t right_i,
  input  twsc_pkg::twsc_lane_t left_i,
  output logic                 captured_o,
  output logic                 cap_en_o,
  output logic [30:0]          cursor_o,
  output twsc_pkg::twsc_res_t  res_o
);
  import twsc_pkg::*;

  logic            captured_q;
  logic            done_q, done_d;
  logic [CurW-1:0] cursor_q, cursor_d;
  logic [TolW-1:0] count_q, count_d;
  logic            out_valid_q;
  twsc_res_t       res_q, res_d;

  logic            accept, drive, both_track, both_end;
  logic [31:0]     gap, gap_mag, sum;
  logic            snap;
  logic [CurW-1:0] advanced;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign drive      = captured_q && !done_q;
  assign both_track = right_i.track_ok && left_i.track_ok;
  assign both_end   = right_i.end_ok && left_i.end_ok;
  assign cap_en_o   = accept && !captured_q;

  // Cursor step: snap to total inside the window, else step and clamp
  assign gap      = {1'b0, cursor_q} - {1'b0, cfg_i.total};
  assign gap_mag  = gap[31] ? (~gap + 32'd1) : gap;
  assign snap     = gap_mag < {16'd0, cfg_i.end_tol};
  assign sum      = {1'b0, cursor_q} + {16'd0, cfg_i.step_tol};
  assign advanced = (snap || (sum > {1'b0, cfg_i.total})) ? cfg_i.total : sum[CurW-1:0];

  always_comb begin
    cursor_d = cursor_q;
    if (accept && drive && both_track) begin
      cursor_d = advanced;
    end
  end

  // Saturating in-tolerance count and finish flag
  always_comb begin
    count_d = count_q;
    if (both_end && (count_q != '1)) begin
      count_d = count_q + 16'd1;
    end
    done_d = (count_d >= cfg_i.hold);
  end

  // Build the result beat
  always_comb begin
    res_d.drive_valid        = drive;
    res_d.right_target       = drive ? right_i.target : '0;
    res_d.left_target        = drive ? left_i.target : '0;
    res_d.progress_cursor    = cursor_q;
    res_d.correction_request = drive && !both_track;
    res_d.move_finished      = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      captured_q  <= 1'b0;
      done_q      <= 1'b0;
      cursor_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      if (accept) begin
        captured_q  <= 1'b1;
        done_q      <= done_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the payload until the next accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign captured_o  = captured_q;
  assign cursor_o    = cursor_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_cursor_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && drive) |=> $stable(cursor_q))
    else $error("cursor moved without an issued target");

  a_corr_needs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.correction_request) |-> res_q.drive_valid)
    else $error("correction request without drive");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q >= $past(count_q)))
    else $error("in-tolerance count decreased");

  a_capture_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(captured_q) |-> $past(accept))
    else $error("references captured without an accepted beat");
`endif

endmodule
